// ===== rtl/rar_pkg.sv =====
// Package for the rational arithmetic reduce block: types, constants and codes.
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W = 33;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               zero_den_error;
  } out_item_t;

  // Classified work handed from the front part to the back part.
  typedef struct packed {
    logic [MAG_W-1:0] nm;
    logic [MAG_W-1:0] dm;
    logic             neg;
    logic             zero_den;
    logic             zero_num;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

endpackage

// ===== rtl/rar_front.sv =====
// Front part: sign extension, cross products, magnitudes and classification.
module rar_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rar_pkg::in_item_t in_data,
  output logic              wk_valid,
  input  logic              wk_stall,
  output rar_pkg::work_t    wk_data
);

  localparam int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH + 2;

  logic                             s1_valid_r, s1_valid_nxt;
  logic signed [OPERAND_WIDTH-1:0]  p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r;
  logic [1:0]                       op_r;
  logic signed [PW-1:0]             m1_r, m2_r, m3_r;
  logic                             s2_valid_r, s2_valid_nxt;
  logic [1:0]                       op2_r;
  logic signed [PW-1:0]             rn, rd;
  logic                             adv1, adv2;

  // Stage 2 output register drains when the queue takes it.
  assign adv2 = !s2_valid_r || !wk_stall;
  assign adv1 = !s1_valid_r || adv2;
  assign in_stall = !adv1;
  assign s1_valid_nxt = adv1 ? in_valid : s1_valid_r;
  assign s2_valid_nxt = adv2 ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Stage 1 registers operand pairs; stage 2 registers the three products.
  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      op_r <= in_data.mode;
      p1a_r <= in_data.a_num[OPERAND_WIDTH-1:0];
      p2a_r <= in_data.b_num[OPERAND_WIDTH-1:0];
      p3a_r <= in_data.a_den[OPERAND_WIDTH-1:0];
      p1b_r <= (in_data.mode == rar_pkg::OP_MUL) ? in_data.b_num[OPERAND_WIDTH-1:0]
                                                 : in_data.b_den[OPERAND_WIDTH-1:0];
      p2b_r <= in_data.a_den[OPERAND_WIDTH-1:0];
      p3b_r <= (in_data.mode == rar_pkg::OP_DIV) ? in_data.b_num[OPERAND_WIDTH-1:0]
                                                 : in_data.b_den[OPERAND_WIDTH-1:0];
    end
    if (adv2 && s1_valid_r) begin
      op2_r <= op_r;
      m1_r <= PW'(p1a_r * p1b_r);
      m2_r <= PW'(p2a_r * p2b_r);
      m3_r <= PW'(p3a_r * p3b_r);
    end
  end

  always_comb begin
    unique case (rar_pkg::op_t'(op2_r))
      rar_pkg::OP_ADD: rn = m1_r + m2_r;
      rar_pkg::OP_SUB: rn = m1_r - m2_r;
      default:         rn = m1_r;
    endcase
    rd = m3_r;
    wk_data.nm       = rn[PW-1] ? rar_pkg::MAG_W'(-rn) : rar_pkg::MAG_W'(rn);
    wk_data.dm       = rd[PW-1] ? rar_pkg::MAG_W'(-rd) : rar_pkg::MAG_W'(rd);
    wk_data.neg      = rn[PW-1] ^ rd[PW-1];
    wk_data.zero_den = (rd == '0);
    wk_data.zero_num = (rn == '0);
  end

  assign wk_valid = s2_valid_r;

endmodule

// ===== rtl/rar_queue.sv =====
// Short queue between the front and back parts.
module rar_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  rar_pkg::work_t wr_data,
  output logic           rd_valid,
  input  logic           rd_stall,
  output rar_pkg::work_t rd_data
);

  localparam int AW = $clog2(rar_pkg::QUEUE_DEPTH);

  rar_pkg::work_t mem_r [rar_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign wr_stall = (cnt_r == (AW+1)'(rar_pkg::QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(rar_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

// ===== rtl/rar_back.sv =====
// Back part: binary GCD, two restoring divisions, sign and saturation.
module rar_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wk_valid,
  output logic               wk_stall,
  input  rar_pkg::work_t     wk_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rar_pkg::out_item_t out_data
);

  localparam int W = rar_pkg::MAG_W;
  localparam int CW = $clog2(W + 1);

  rar_pkg::bk_state_t st_r, st_nxt;
  logic [W-1:0]  nm_r, dm_r, u_r, v_r, g_r;
  logic [CW-1:0] sh_r, bit_r;
  logic [W-1:0]  rem_r, quo_r, qn_r;
  logic          neg_r;
  rar_pkg::out_item_t res_r;
  logic [W-1:0]  remsh, diff, qd;
  logic          ge;

  assign remsh = {rem_r[W-2:0], (st_r == rar_pkg::BK_DIVN) ? nm_r[bit_r[CW-1:0]-:1]
                                                             : dm_r[bit_r[CW-1:0]-:1]};
  assign ge = remsh >= g_r;
  assign diff = remsh - g_r;
  assign wk_stall = (st_r != rar_pkg::BK_IDLE);
  assign out_valid = (st_r == rar_pkg::BK_OUT);
  assign out_data = res_r;
  assign qd = {quo_r[W-2:0], ge};

  function automatic logic [30:0] sat(input logic [W-1:0] x);
    return (x > W'(31'h7fffffff)) ? 31'h7fffffff : x[30:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rar_pkg::BK_IDLE: if (wk_valid) st_nxt = (wk_data.zero_den || wk_data.zero_num)
                                               ? rar_pkg::BK_OUT : rar_pkg::BK_GCD;
      rar_pkg::BK_GCD:  if (v_r == '0) st_nxt = rar_pkg::BK_DIVN;
      rar_pkg::BK_DIVN: if (bit_r == '0) st_nxt = rar_pkg::BK_DIVD;
      rar_pkg::BK_DIVD: if (bit_r == '0) st_nxt = rar_pkg::BK_OUT;
      rar_pkg::BK_OUT:  if (!out_stall) st_nxt = rar_pkg::BK_IDLE;
      default:          st_nxt = rar_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= rar_pkg::BK_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      rar_pkg::BK_IDLE: if (wk_valid) begin
        nm_r <= wk_data.nm;
        dm_r <= wk_data.dm;
        u_r <= wk_data.nm;
        v_r <= wk_data.dm;
        sh_r <= '0;
        neg_r <= wk_data.neg;
        res_r.zero_den_error <= wk_data.zero_den;
        res_r.res_num <= '0;
        res_r.res_den <= wk_data.zero_den ? '0 : sat(wk_data.dm);
      end
      rar_pkg::BK_GCD: begin
        // Binary GCD: one shift or one subtract per cycle.
        if (v_r == '0) begin
          g_r <= u_r << sh_r;
          bit_r <= CW'(W - 1);
          rem_r <= '0;
          quo_r <= '0;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          sh_r <= sh_r + 1'b1;
        end else if (!u_r[0]) u_r <= u_r >> 1;
        else if (!v_r[0]) v_r <= v_r >> 1;
        else if (u_r > v_r) u_r <= u_r - v_r;
        else v_r <= v_r - u_r;
      end
      rar_pkg::BK_DIVN, rar_pkg::BK_DIVD: begin
        if (bit_r == '0) begin
          rem_r <= '0;
          quo_r <= '0;
          bit_r <= CW'(W - 1);
          if (st_r == rar_pkg::BK_DIVN) qn_r <= qd;
          else begin
            res_r.res_num <= neg_r ? -32'(sat(qn_r)) : 32'(sat(qn_r));
            res_r.res_den <= sat(qd);
          end
        end else begin
          rem_r <= ge ? diff : remsh;
          quo_r <= qd;
          bit_r <= bit_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rar_pkg::BK_OUT && out_stall) |=> $stable(res_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rar_pkg::BK_DIVN) |-> (g_r != '0))
    else $error("division by zero gcd");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && res_r.zero_den_error) |-> (res_r.res_num == '0 && res_r.res_den == '0))
    else $error("error result not zero");

endmodule

// ===== rtl/rational_arithmetic_reduce.sv =====
// Top level of the rational arithmetic reduce block.
// Path: front stage 1 and stage 2 registers, a queue entry and the back load in
// BK_IDLE; a zero numerator or zero denominator result then goes straight to BK_OUT.
// Otherwise the back part runs the binary GCD steps and two 33-step divisions for
// each transaction; the back part takes one at a time.
// The front part and queue take up to four more meanwhile. Reset: synchronous
// active-low rst_n clears all valid and state flags.
module rational_arithmetic_reduce (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rar_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rar_pkg::out_item_t out_data
);

  // Front to queue and queue to back transaction channels.
  logic           fq_valid, fq_stall, qb_valid, qb_stall;
  rar_pkg::work_t fq_data, qb_data;

  // The front part forms the raw cross products and classifies them.
  rar_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .wk_valid(fq_valid), .wk_stall(fq_stall), .wk_data(fq_data)
  );

  // The queue lets the front keep accepting while the back iterates.
  rar_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
  );

  // The back part reduces nonzero results to lowest terms and holds the result register.
  rar_back u_back (
    .clk, .rst_n,
    .wk_valid(qb_valid), .wk_stall(qb_stall), .wk_data(qb_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
